FILE: sv/scsd_pkg.sv
// Shared types and constants for the sound command stream decoder.
// No dependencies; imported by every module of the block.
package scsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 14;
    localparam int VALUE_W = 16;
    localparam int BASE_W  = 20;
    localparam int SRC_W   = 24;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_WAVE_BASE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_STREAM_BASE = 2'd1;

    localparam logic [7:0] OP_PORT_BYTE_XOR = 8'hC0;
    localparam logic [7:0] OP_PORT_WORD_XOR = 8'hE0;
    localparam logic [7:0] OP_CALL_JUMP     = 8'hEF;
    localparam logic [7:0] OP_WAIT_FIRST    = 8'hF0;
    localparam logic [7:0] OP_WAIT_LAST     = 8'hF6;
    localparam logic [7:0] OP_WAIT_BYTE     = 8'hF8;
    localparam logic [7:0] OP_WAIT_WORD     = 8'hF9;
    localparam logic [7:0] OP_JUMP          = 8'hFA;
    localparam logic [7:0] OP_DMA           = 8'hFB;
    localparam logic [7:0] OP_WAVE_FIRST    = 8'hFC;
    localparam logic [7:0] OP_WAVE_LAST     = 8'hFF;
    localparam logic [7:0] OP_WAIT_BIAS     = 8'hEF;

    localparam logic [2:0] GRP_MEM_LO    = 3'b000;
    localparam logic [2:0] GRP_MEM_HI    = 3'b001;
    localparam logic [2:0] GRP_PORT_BYTE = 3'b010;
    localparam logic [2:0] GRP_PORT_WORD = 3'b011;
    localparam logic [2:0] GRP_SYSTEM    = 3'b111;

    typedef enum logic [3:0] {
        PH_OPCODE   = 4'd0,
        PH_MEM_LEN  = 4'd1,
        PH_MEM_DATA = 4'd2,
        PH_OPER_LO  = 4'd3,
        PH_OPER_HI  = 4'd4,
        PH_DMA_CTRL = 4'd5,
        PH_DOFF_LO  = 4'd6,
        PH_DOFF_HI  = 4'd7,
        PH_DCNT_LO  = 4'd8,
        PH_DCNT_HI  = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        ACT_PORT_BYTE = 4'd0,
        ACT_PORT_WORD = 4'd1,
        ACT_RAM_BYTE  = 4'd2,
        ACT_WAVE_COPY = 4'd3,
        ACT_WAIT      = 4'd4,
        ACT_JUMP      = 4'd5,
        ACT_CALL_JUMP = 4'd6,
        ACT_DMA_STOP  = 4'd7,
        ACT_DMA_START = 4'd8
    } t_action;

    typedef struct packed {
        logic                valid;
        t_action             action;
        logic [ADDR_W-1:0]   address;
        logic [VALUE_W-1:0]  value;
        logic [SRC_W-1:0]    dma_source;
        logic [BYTE_W-1:0]   dma_control;
    } t_result;

endpackage

FILE: sv/sound_command_stream_decoder.sv
// Sound command stream decoder: one stream byte in, at most one action out.
// Each byte passes the input register, the parser, then the output register.
// One byte per cycle unless the output stalls; one parser update per byte.
// Reset (synchronous, active low): parser back to expecting an opcode, all held
// operands and both configuration registers cleared, both stages empty.
// Depends on scsd_pkg, scsd_in_reg, scsd_parser and scsd_out_reg.
module sound_command_stream_decoder import scsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [BASE_W-1:0]  i_cfg_data,
    // byte input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_data_byte,
    // action output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_action,
    output logic [ADDR_W-1:0]  o_address,
    output logic [VALUE_W-1:0] o_value,
    output logic [SRC_W-1:0]   o_dma_source,
    output logic [BYTE_W-1:0]  o_dma_control
);

    logic              held;
    logic [BYTE_W-1:0] held_byte;
    logic              space;
    logic              fire;
    t_result           parsed;
    t_result           result;

    // Parse the held byte only when the result register can take its request.
    assign fire = held && space;

    scsd_in_reg u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_take      (space),
        .o_held      (held),
        .o_byte      (held_byte)
    );

    scsd_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_byte      (held_byte),
        .o_result    (parsed)
    );

    // Drop bytes that make no action; only real requests reach the output.
    scsd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (parsed),
        .o_space  (space),
        .o_result (result),
        .i_ready  (i_ready)
    );

    assign o_valid       = result.valid;
    assign o_action      = result.action;
    assign o_address     = result.address;
    assign o_value       = result.value;
    assign o_dma_source  = result.dma_source;
    assign o_dma_control = result.dma_control;

endmodule

FILE: sv/scsd_in_reg.sv
// Input register stage of the sound command stream decoder.
// Depends on scsd_pkg for the byte width.
module scsd_in_reg import scsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_take,
    output logic              o_held,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_held;
    logic [BYTE_W-1:0] r_byte;

    // Free the slot when it is empty or the parser takes the held byte this cycle.
    assign o_ready = !r_held || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (o_ready) begin
            r_held <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_held = r_held;
    assign o_byte = r_byte;

endmodule

FILE: sv/scsd_parser.sv
// Parser state and per-byte decode of the sound command stream.
// Depends on scsd_pkg for phases, actions, opcodes and the result struct.
module scsd_parser import scsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [BASE_W-1:0] i_cfg_data,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    logic [BYTE_W-1:0]  r_wave_base;
    logic [BASE_W-1:0]  r_stream_base;
    t_phase             r_phase,    n_phase;
    logic [BYTE_W-1:0]  r_opcode,   n_opcode;
    logic [BYTE_W-1:0]  r_remain,   n_remain;
    logic [BYTE_W-1:0]  r_hold,     n_hold;
    logic [ADDR_W-1:0]  r_ram_addr, n_ram_addr;
    logic [BYTE_W-1:0]  r_dma_ctl,  n_dma_ctl;
    logic [VALUE_W-1:0] r_dma_off,  n_dma_off;
    t_result            n_result;

    function automatic t_result make(input t_action act, input logic [ADDR_W-1:0] addr,
                                     input logic [VALUE_W-1:0] val);
        t_result res;
        res             = '0;
        res.valid       = 1'b1;
        res.action      = act;
        res.address     = addr;
        res.value       = val;
        return res;
    endfunction

    // Close out a one- or two-byte operand for the current opcode.
    function automatic t_result finish(input logic [BYTE_W-1:0] op,
                                       input logic [VALUE_W-1:0] v,
                                       input logic [BYTE_W-1:0] wave_base);
        t_result res;
        res = '0;
        if (op[7:5] == GRP_PORT_BYTE) begin
            res = make(ACT_PORT_BYTE, ADDR_W'(op ^ OP_PORT_BYTE_XOR), v);
        end else if (op[7:5] == GRP_PORT_WORD) begin
            res = make(ACT_PORT_WORD, ADDR_W'(op ^ OP_PORT_WORD_XOR), v);
        end else if (op == OP_CALL_JUMP) begin
            res = make(ACT_CALL_JUMP, '0, v);
        end else if (op == OP_WAIT_BYTE || op == OP_WAIT_WORD) begin
            if (v != '0) begin
                res = make(ACT_WAIT, '0, v);
            end
        end else if (op == OP_JUMP) begin
            res = make(ACT_JUMP, '0, v);
        end else if (op >= OP_WAVE_FIRST) begin
            res = make(ACT_WAVE_COPY, {wave_base, op[1:0], 4'b0000}, v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_base   <= '0;
            r_stream_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_BASE:   r_wave_base   <= i_cfg_data[BYTE_W-1:0];
                CFG_STREAM_BASE: r_stream_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_remain   = r_remain;
        n_hold     = r_hold;
        n_ram_addr = r_ram_addr;
        n_dma_ctl  = r_dma_ctl;
        n_dma_off  = r_dma_off;
        n_result   = '0;
        case (r_phase)
            PH_MEM_LEN: begin
                n_remain = i_byte;
                n_phase  = (i_byte != '0) ? PH_MEM_DATA : PH_OPCODE;
            end
            PH_MEM_DATA: begin
                n_result   = make(ACT_RAM_BYTE, r_ram_addr, VALUE_W'(i_byte));
                n_ram_addr = r_ram_addr + 1'b1;
                n_remain   = r_remain - 1'b1;
                if (n_remain == '0) begin
                    n_phase = PH_OPCODE;
                end
            end
            PH_OPER_LO: begin
                if (r_opcode[7:5] == GRP_PORT_BYTE || r_opcode == OP_WAIT_BYTE) begin
                    n_result = finish(r_opcode, VALUE_W'(i_byte), r_wave_base);
                    n_phase  = PH_OPCODE;
                end else begin
                    n_hold  = i_byte;
                    n_phase = PH_OPER_HI;
                end
            end
            PH_OPER_HI: begin
                n_result = finish(r_opcode, {i_byte, r_hold}, r_wave_base);
                n_phase  = PH_OPCODE;
            end
            PH_DMA_CTRL: begin
                n_dma_ctl = i_byte;
                n_phase   = i_byte[7] ? PH_DOFF_LO : PH_OPCODE;
                n_result  = make(ACT_DMA_STOP, '0, '0);
            end
            PH_DOFF_LO: begin
                n_hold  = i_byte;
                n_phase = PH_DOFF_HI;
            end
            PH_DOFF_HI: begin
                n_dma_off = {i_byte, r_hold};
                n_phase   = PH_DCNT_LO;
            end
            PH_DCNT_LO: begin
                n_hold  = i_byte;
                n_phase = PH_DCNT_HI;
            end
            PH_DCNT_HI: begin
                n_result             = make(ACT_DMA_START, '0, {i_byte, r_hold});
                n_result.dma_source  = SRC_W'(r_stream_base) + SRC_W'(r_dma_off);
                n_result.dma_control = r_dma_ctl;
                n_phase              = PH_OPCODE;
            end
            default: begin
                // Opcode byte; unused opcodes fall through as no-ops.
                n_phase  = PH_OPCODE;
                n_opcode = i_byte;
                case (i_byte[7:5])
                    GRP_MEM_LO, GRP_MEM_HI: begin
                        n_ram_addr = {r_wave_base, i_byte[5:0]};
                        n_phase    = PH_MEM_LEN;
                    end
                    GRP_PORT_BYTE, GRP_PORT_WORD: begin
                        n_phase = PH_OPER_LO;
                    end
                    GRP_SYSTEM: begin
                        case (i_byte) inside
                            [OP_WAIT_FIRST:OP_WAIT_LAST]: begin
                                n_result = make(ACT_WAIT, '0,
                                                VALUE_W'(i_byte - OP_WAIT_BIAS));
                            end
                            OP_DMA: begin
                                n_phase = PH_DMA_CTRL;
                            end
                            OP_CALL_JUMP, OP_WAIT_BYTE, OP_WAIT_WORD, OP_JUMP,
                            [OP_WAVE_FIRST:OP_WAVE_LAST]: begin
                                n_phase = PH_OPER_LO;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPCODE;
            r_opcode   <= '0;
            r_remain   <= '0;
            r_hold     <= '0;
            r_ram_addr <= '0;
            r_dma_ctl  <= '0;
            r_dma_off  <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_remain   <= n_remain;
            r_hold     <= n_hold;
            r_ram_addr <= n_ram_addr;
            r_dma_ctl  <= n_dma_ctl;
            r_dma_off  <= n_dma_off;
        end
    end

    assign o_result = n_result;

endmodule

FILE: sv/scsd_out_reg.sv
// Result register stage of the sound command stream decoder.
// Depends on scsd_pkg for the result struct.
module scsd_out_reg import scsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_result;

    // Advance whenever the held request is gone or leaves this cycle.
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load && i_result.valid) begin
            r_result <= i_result;
        end
    end

    always_comb begin
        o_result       = r_result;
        o_result.valid = r_valid;
    end

endmodule
